>>> sv/wcst_pkg.sv
`timescale 1ns / 1ps

package wcst_pkg;

    // accepted window for wall-clock seconds, 2021-01-01 .. 2100-01-01
    localparam logic [32:0] TIME_LOW  = 33'd1609459200;
    localparam logic [32:0] TIME_HIGH = 33'd4102444800;

    // configuration limits
    localparam logic [19:0] AGE_LOW  = 20'd60;
    localparam logic [19:0] AGE_HIGH = 20'd604800;
    localparam logic [8:0]  TOL_HIGH = 9'd300;
    localparam logic [29:0] AGEK_RESET = 30'd3600000;
    localparam logic [18:0] TOLK_RESET = 19'd1000;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_TOL = 1'b1;

    // input function codes
    localparam logic FUNC_SYNC  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // widths of the millisecond-scaled quantities
    localparam int CANDK_W = 43;
    localparam int KA_W    = 42;
    localparam int CMP_W   = 44;
    localparam int AGEK_W  = 30;
    localparam int TOLK_W  = 19;
    localparam int CT_W    = 32;
    localparam int AGE_W   = 39;

    // (TIME_HIGH + 1) * 1000: elapsed ms must stay below limit = this - anchor*1000
    localparam logic [KA_W-1:0] LIMIT_K = 42'd4102444801000;

    // el / 1000 = (el >> 3) / 125, done as floor(x * DIV_M / 2^DIV_SHIFT)
    localparam int DIV_X_W  = 39;
    localparam int DIV_LO_W = 20;
    localparam int DIV_HI_W = DIV_X_W - DIV_LO_W;
    localparam int DIV_M_W  = 40;
    localparam int DIV_SHIFT = 46;
    localparam logic [DIV_M_W-1:0] DIV_M = 40'd562949953422;

    typedef struct packed {
        logic            accepted;
        logic            est_ok;
        logic            fresh;
        logic [CT_W-1:0] anchor_time;
    } wcst_ctl_t;

    function automatic logic [CANDK_W-1:0] mul1000(input logic [32:0] x);
        logic [CANDK_W-1:0] xe;
        xe = CANDK_W'(x);
        return (xe << 10) - (xe << 4) - (xe << 3);
    endfunction

endpackage

>>> sv/wcst_anchor.sv
`timescale 1ns / 1ps

module wcst_anchor #(
    parameter int MS_WIDTH = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            func,
    input  logic [32:0]                     cand,
    input  logic [wcst_pkg::CANDK_W-1:0]    cand_k,
    input  logic [MS_WIDTH-1:0]             ms,
    input  logic [wcst_pkg::AGEK_W-1:0]     agek,
    input  logic [wcst_pkg::TOLK_W-1:0]     tolk,
    output wcst_pkg::wcst_ctl_t             ctl,
    output logic [wcst_pkg::DIV_X_W-1:0]    div_x
);

    localparam int EXT_W = (MS_WIDTH > wcst_pkg::CMP_W) ? MS_WIDTH : wcst_pkg::CMP_W;

    logic                          synced_reg;
    logic [wcst_pkg::CT_W-1:0]     anchor_time_reg;
    logic [MS_WIDTH-1:0]           anchor_ms_reg;
    logic [wcst_pkg::KA_W-1:0]     ka_reg;
    logic [wcst_pkg::KA_W-1:0]     limit_reg;
    wcst_pkg::wcst_ctl_t           ctl_reg;
    logic [wcst_pkg::DIV_X_W-1:0]  div_x_reg;

    logic [MS_WIDTH-1:0]       el;
    logic [EXT_W-1:0]          el_ext;
    logic                      behind_anchor;
    logic                      est_ok;
    logic                      fresh;
    logic [wcst_pkg::CMP_W-1:0] back_lhs;
    logic [wcst_pkg::CMP_W-1:0] back_rhs;
    logic                      too_far;
    logic                      cand_ok;
    logic                      take;

    always_comb begin
        el            = ms - anchor_ms_reg;
        el_ext        = EXT_W'(el);
        behind_anchor = ms < anchor_ms_reg;
        est_ok  = synced_reg && !behind_anchor && (el_ext < EXT_W'(limit_reg));
        fresh   = est_ok && (el_ext <= EXT_W'(agek));
        // estimate > cand + tol  <=>  el + anchor*1000 >= (cand + tol + 1) * 1000
        back_lhs = el_ext[wcst_pkg::CMP_W-1:0] + wcst_pkg::CMP_W'(ka_reg);
        back_rhs = wcst_pkg::CMP_W'(cand_k) + wcst_pkg::CMP_W'(tolk);
        too_far  = back_lhs >= back_rhs;
        cand_ok  = (cand >= wcst_pkg::TIME_LOW) && (cand <= wcst_pkg::TIME_HIGH);
        take     = (func == wcst_pkg::FUNC_SYNC) && cand_ok &&
                   (!synced_reg || (est_ok && !too_far));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg <= 1'b0;
        end else if (en && take) begin
            synced_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (take) begin
                anchor_time_reg <= cand[wcst_pkg::CT_W-1:0];
                anchor_ms_reg   <= ms;
                ka_reg          <= cand_k[wcst_pkg::KA_W-1:0];
                limit_reg       <= wcst_pkg::LIMIT_K - cand_k[wcst_pkg::KA_W-1:0];
            end
            ctl_reg.accepted    <= take;
            ctl_reg.est_ok      <= (func == wcst_pkg::FUNC_QUERY) && est_ok;
            ctl_reg.fresh       <= (func == wcst_pkg::FUNC_QUERY) && fresh;
            ctl_reg.anchor_time <= anchor_time_reg;
            div_x_reg           <= el_ext[wcst_pkg::DIV_X_W+2:3];
        end
    end

    assign ctl   = ctl_reg;
    assign div_x = div_x_reg;

endmodule

>>> sv/wcst_div1000.sv
`timescale 1ns / 1ps

module wcst_div1000 (
    input  logic                            aclk,
    input  logic                            en,
    input  wcst_pkg::wcst_ctl_t             ctl_in,
    input  logic [wcst_pkg::DIV_X_W-1:0]    x_in,
    output wcst_pkg::wcst_ctl_t             ctl_out,
    output logic [wcst_pkg::CT_W-1:0]       q_out
);

    localparam int PH_W  = wcst_pkg::DIV_HI_W + wcst_pkg::DIV_M_W;
    localparam int PL_W  = wcst_pkg::DIV_LO_W + wcst_pkg::DIV_M_W;
    localparam int SUM_W = wcst_pkg::DIV_X_W + wcst_pkg::DIV_M_W;

    logic [PH_W-1:0]            ph_reg;
    logic [PL_W-1:0]            pl_reg;
    wcst_pkg::wcst_ctl_t        ctl_b_reg;
    wcst_pkg::wcst_ctl_t        ctl_c_reg;
    logic [wcst_pkg::CT_W-1:0]  q_reg;

    logic [SUM_W-1:0] sum;

    // two partial products of the reciprocal multiply, registered and then summed into q_reg
    always_comb begin
        sum = SUM_W'({ph_reg, {wcst_pkg::DIV_LO_W{1'b0}}}) + SUM_W'(pl_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg    <= PH_W'(x_in[wcst_pkg::DIV_X_W-1:wcst_pkg::DIV_LO_W]) *
                         PH_W'(wcst_pkg::DIV_M);
            pl_reg    <= PL_W'(x_in[wcst_pkg::DIV_LO_W-1:0]) * PL_W'(wcst_pkg::DIV_M);
            ctl_b_reg <= ctl_in;
            q_reg     <= sum[wcst_pkg::DIV_SHIFT+wcst_pkg::CT_W-1:wcst_pkg::DIV_SHIFT];
            ctl_c_reg <= ctl_b_reg;
        end
    end

    assign ctl_out = ctl_c_reg;
    assign q_out   = q_reg;

endmodule

>>> sv/wall_clock_sync_tracker.sv
`timescale 1ns / 1ps

// a taken beat runs through the input, anchor, two divider and output registers
// throughput: one item per cycle; the whole pipe stalls only while a result waits
// the anchor state updates in one stage, so a sync is seen by the very next item
// el / 1000 runs as a two-stage reciprocal multiply behind the anchor stage
// reset (synchronous, active low) empties the pipe, clears sync, max age 3600 s, tolerance 0
module wall_clock_sync_tracker #(
    parameter int MS_WIDTH = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [32:0]                       s_candidate_time,
    input  logic [47:0]                       s_monotonic_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic                              m_estimate_ok,
    output logic                              m_fresh,
    output logic [wcst_pkg::CT_W-1:0]         m_current_time,
    output logic [wcst_pkg::AGE_W-1:0]        m_elapsed_s,
    input  logic                              cfg_we,
    input  logic [wcst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [19:0]                       cfg_data
);

    localparam int MSX_W = (MS_WIDTH > 48) ? MS_WIDTH : 48;

    logic adv;

    logic                         in_v_reg;
    logic                         a_v_reg;
    logic                         b_v_reg;
    logic                         c_v_reg;
    logic                         m_valid_reg;
    logic                         in_func_reg;
    logic [32:0]                  in_cand_reg;
    logic [wcst_pkg::CANDK_W-1:0] in_candk_reg;
    logic [MS_WIDTH-1:0]          in_ms_reg;

    logic [wcst_pkg::AGEK_W-1:0]  agek_reg;
    logic [wcst_pkg::TOLK_W-1:0]  tolk_reg;

    logic                         m_accepted_reg;
    logic                         m_estimate_ok_reg;
    logic                         m_fresh_reg;
    logic [wcst_pkg::CT_W-1:0]    m_current_time_reg;
    logic [wcst_pkg::AGE_W-1:0]   m_elapsed_s_reg;

    logic [MSX_W-1:0]             ms_ext;
    logic [wcst_pkg::CANDK_W-1:0] age_prod;
    logic [wcst_pkg::CANDK_W-1:0] tol_prod;

    wcst_pkg::wcst_ctl_t          ctl_a;
    logic [wcst_pkg::DIV_X_W-1:0] div_x;
    wcst_pkg::wcst_ctl_t          ctl_c;
    logic [wcst_pkg::CT_W-1:0]    q_c;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign ms_ext  = MSX_W'(s_monotonic_ms);

    always_comb begin
        age_prod = wcst_pkg::mul1000(33'(cfg_data));
        tol_prod = wcst_pkg::mul1000(33'(cfg_data[8:0]) + 33'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agek_reg <= wcst_pkg::AGEK_RESET;
            tolk_reg <= wcst_pkg::TOLK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wcst_pkg::CFG_MAX_AGE: begin
                    if (cfg_data >= wcst_pkg::AGE_LOW && cfg_data <= wcst_pkg::AGE_HIGH) begin
                        agek_reg <= age_prod[wcst_pkg::AGEK_W-1:0];
                    end
                end
                wcst_pkg::CFG_BACK_TOL: begin
                    if (cfg_data[8:0] <= wcst_pkg::TOL_HIGH) begin
                        tolk_reg <= tol_prod[wcst_pkg::TOLK_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg    <= 1'b0;
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            c_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg    <= s_valid;
            a_v_reg     <= in_v_reg;
            b_v_reg     <= a_v_reg;
            c_v_reg     <= b_v_reg;
            m_valid_reg <= c_v_reg;
        end
    end

    // candidate scaled to ms on the way in, keeps the anchor stage short
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_func_reg  <= s_func;
            in_cand_reg  <= s_candidate_time;
            in_candk_reg <= wcst_pkg::mul1000(s_candidate_time);
            in_ms_reg    <= ms_ext[MS_WIDTH-1:0];
        end
    end

    wcst_anchor #(
        .MS_WIDTH (MS_WIDTH)
    ) u_anchor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv && in_v_reg),
        .func    (in_func_reg),
        .cand    (in_cand_reg),
        .cand_k  (in_candk_reg),
        .ms      (in_ms_reg),
        .agek    (agek_reg),
        .tolk    (tolk_reg),
        .ctl     (ctl_a),
        .div_x   (div_x)
    );

    wcst_div1000 u_div (
        .aclk    (aclk),
        .en      (adv),
        .ctl_in  (ctl_a),
        .x_in    (div_x),
        .ctl_out (ctl_c),
        .q_out   (q_c)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_accepted_reg    <= ctl_c.accepted;
            m_estimate_ok_reg <= ctl_c.est_ok;
            m_fresh_reg       <= ctl_c.fresh;
            m_current_time_reg <= ctl_c.est_ok ? (ctl_c.anchor_time + q_c) : '0;
            m_elapsed_s_reg    <= ctl_c.est_ok ? wcst_pkg::AGE_W'(q_c) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accepted     = m_accepted_reg;
    assign m_estimate_ok  = m_estimate_ok_reg;
    assign m_fresh        = m_fresh_reg;
    assign m_current_time = m_current_time_reg;
    assign m_elapsed_s    = m_elapsed_s_reg;

    a_fresh_needs_estimate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fresh |-> m_estimate_ok)
        else $error("fresh result without a valid estimate");

    a_sync_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> !m_estimate_ok && m_current_time == '0 &&
                                  m_elapsed_s == '0)
        else $error("taken sync beat carries query fields");

    a_estimate_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_estimate_ok |-> 33'(m_current_time) >= wcst_pkg::TIME_LOW &&
                                     33'(m_current_time) <= wcst_pkg::TIME_HIGH)
        else $error("estimate outside the wall-clock window");

    a_beat_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_v_reg)
        else $error("accepted beat lost at the input register");

endmodule

>>> sim/wall_clock_sync_tracker_tb.sv
`timescale 1ns / 1ps

module wall_clock_sync_tracker_tb;

    localparam longint unsigned SPAN_MS =
        (64'(wcst_pkg::TIME_HIGH) - 64'(wcst_pkg::TIME_LOW)) * 64'd1000;

    typedef struct packed {
        logic                       accepted;
        logic                       estimate_ok;
        logic                       fresh;
        logic [wcst_pkg::CT_W-1:0]  current_time;
        logic [wcst_pkg::AGE_W-1:0] elapsed_s;
    } tracker_result_t;

    class clock_sync_scoreboard;
        bit              synced;
        longint unsigned anchor_time;
        longint unsigned anchor_ms;
        longint unsigned max_age;
        longint unsigned back_tol;
        tracker_result_t pending_results[$];
        int              failures;

        function new();
            synced      = 1'b0;
            anchor_time = 0;
            anchor_ms   = 0;
            max_age     = 3600;
            back_tol    = 0;
            failures    = 0;
        endfunction

        function void write_reg(logic [wcst_pkg::CFG_IDX_W-1:0] idx, logic [19:0] data);
            if (idx == wcst_pkg::CFG_MAX_AGE) begin
                if (data >= wcst_pkg::AGE_LOW && data <= wcst_pkg::AGE_HIGH)
                    max_age = 64'(data);
            end else if (idx == wcst_pkg::CFG_BACK_TOL) begin
                // only the low 9 bits reach the tolerance register
                if (data[8:0] <= wcst_pkg::TOL_HIGH)
                    back_tol = 64'(data[8:0]);
            end
        endfunction

        function bit wall_time_at(input longint unsigned now, output longint unsigned est,
                                  output longint unsigned el);
            longint unsigned secs;
            est = 0;
            el  = 0;
            if (!synced || now < anchor_ms || anchor_time > 64'(wcst_pkg::TIME_HIGH))
                return 1'b0;
            el   = now - anchor_ms;
            secs = el / 64'd1000;
            if (secs > 64'(wcst_pkg::TIME_HIGH) - anchor_time)
                return 1'b0;
            est = anchor_time + secs;
            return est >= 64'(wcst_pkg::TIME_LOW) && est <= 64'(wcst_pkg::TIME_HIGH);
        endfunction

        function void note_request(logic func, logic [32:0] cand, logic [47:0] stamp);
            tracker_result_t r;
            longint unsigned est;
            longint unsigned el;
            bit              take;
            r = '0;
            if (func == wcst_pkg::FUNC_SYNC) begin
                take = cand >= wcst_pkg::TIME_LOW && cand <= wcst_pkg::TIME_HIGH;
                if (take && synced) begin
                    if (!wall_time_at(64'(stamp), est, el))
                        take = 1'b0;
                    else if (64'(cand) < est && est - 64'(cand) > back_tol)
                        take = 1'b0;
                end
                if (take) begin
                    synced      = 1'b1;
                    anchor_time = 64'(cand);
                    anchor_ms   = 64'(stamp);
                    r.accepted  = 1'b1;
                end
            end else if (wall_time_at(64'(stamp), est, el)) begin
                r.estimate_ok  = 1'b1;
                r.fresh        = el <= max_age * 64'd1000;
                r.current_time = est[wcst_pkg::CT_W-1:0];
                r.elapsed_s    = wcst_pkg::AGE_W'(el / 64'd1000);
            end
            pending_results.push_back(r);
        endfunction

        function string show(tracker_result_t r);
            return $sformatf("acc %0b ok %0b fresh %0b time %0d age %0d",
                             r.accepted, r.estimate_ok, r.fresh, r.current_time, r.elapsed_s);
        endfunction

        function void report_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void check_response(tracker_result_t got);
            tracker_result_t want;
            if (pending_results.size() == 0) begin
                report_failure({"unexpected result beat: ", show(got)});
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted || got.estimate_ok !== want.estimate_ok ||
                got.fresh !== want.fresh || got.current_time !== want.current_time ||
                got.elapsed_s !== want.elapsed_s)
                report_failure({"mismatch: exp ", show(want), ", got ", show(got)});
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_func = wcst_pkg::FUNC_SYNC;
    logic [32:0]                      s_candidate_time = '0;
    logic [47:0]                      s_monotonic_ms = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic                             m_accepted;
    logic                             m_estimate_ok;
    logic                             m_fresh;
    logic [wcst_pkg::CT_W-1:0]        m_current_time;
    logic [wcst_pkg::AGE_W-1:0]       m_elapsed_s;
    logic                             cfg_we = 1'b0;
    logic [wcst_pkg::CFG_IDX_W-1:0]   cfg_index = wcst_pkg::CFG_MAX_AGE;
    logic [19:0]                      cfg_data = '0;

    clock_sync_scoreboard   sb = new();
    int                     send_idle = 0;
    int                     recv_idle = 0;
    longint unsigned        now_ms = 0;

    wall_clock_sync_tracker #(
        .MS_WIDTH(48)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_candidate_time(s_candidate_time),
        .s_monotonic_ms  (s_monotonic_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_estimate_ok   (m_estimate_ok),
        .m_fresh         (m_fresh),
        .m_current_time  (m_current_time),
        .m_elapsed_s     (m_elapsed_s),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_response({m_accepted, m_estimate_ok, m_fresh, m_current_time,
                               m_elapsed_s});
    end

    // entered and left at a falling edge
    task automatic send_item(input logic func, input logic [32:0] cand, input logic [47:0] stamp);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= func;
        s_candidate_time <= cand;
        s_monotonic_ms   <= stamp;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(func, cand, stamp);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [wcst_pkg::CFG_IDX_W-1:0] idx, input logic [19:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_phase(input int count);
        int              kind;
        logic            f;
        logic [32:0]     c;
        logic [47:0]     t;
        longint unsigned est;
        longint signed   delta;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            f    = wcst_pkg::FUNC_QUERY;
            c    = 33'({$urandom, $urandom});
            if ($urandom_range(99) < 8)
                now_ms += 64'($urandom_range(32'(sb.max_age * 64'd2000), 0));
            else
                now_ms += 64'($urandom_range(3000, 0));
            t = 48'(now_ms);
            if (kind < 30) begin
                // sync offer around the running estimate, sometimes past the tolerance
                f = wcst_pkg::FUNC_SYNC;
                if (sb.synced) begin
                    est   = sb.anchor_time + (now_ms - sb.anchor_ms) / 64'd1000;
                    delta = longint'($urandom_range(32'(sb.back_tol) + 32'd40, 0))
                            - longint'(sb.back_tol) - 64'sd3;
                    c     = 33'(longint'(est) + delta);
                end else begin
                    c = 33'(wcst_pkg::TIME_LOW) + 33'($urandom_range(1000000, 0));
                end
            end else if (kind < 75) begin
                f = wcst_pkg::FUNC_QUERY;
            end else if (kind < 83) begin
                // stamp behind the anchor
                f = 1'($urandom_range(1, 0));
                t = 48'(sb.anchor_ms - 64'($urandom_range(
                        32'(sb.anchor_ms < 64'd5000 ? sb.anchor_ms : 64'd5000), 1)));
            end else if (kind < 90) begin
                // age right at the freshness limit
                t = 48'(sb.anchor_ms + sb.max_age * 64'd1000 - 64'd1 +
                        64'($urandom_range(2, 0)));
            end else if (kind < 95) begin
                f = wcst_pkg::FUNC_SYNC;
                case ($urandom_range(2, 0))
                    0: c = 33'($urandom_range(32'(wcst_pkg::TIME_LOW) - 32'd1, 0));
                    1: c = 33'($urandom_range(32'hFFFF_FFFF, 32'(wcst_pkg::TIME_HIGH) + 32'd1));
                    default: c = {1'b1, $urandom};
                endcase
                if ($urandom_range(1, 0))
                    t = 48'({$urandom, $urandom});
            end else begin
                t = 48'({$urandom, $urandom});
            end
            send_item(f, c, t);
            if (now_ms < sb.anchor_ms)
                now_ms = sb.anchor_ms;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 30;
        recv_idle = 46;
        send_item(wcst_pkg::FUNC_QUERY, '0, '0);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW - 33'd1, '0);
        send_item(wcst_pkg::FUNC_SYNC, '0, '0);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_HIGH + 33'd1, '0);
        send_item(wcst_pkg::FUNC_SYNC, '1, '1);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW, 48'd1000);
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'd1000);
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'd999);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW, 48'd500);
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'd3601000);
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'd3601001);
        // last millisecond that still lands on the 2100 bound, then one past it
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'(SPAN_MS + 64'd1999));
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'(SPAN_MS + 64'd2000));
        send_item(wcst_pkg::FUNC_QUERY, '0, '1);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW + 33'd5, 48'(SPAN_MS + 64'd2000));
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW + 33'd9, 48'd11000);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW + 33'd10, 48'd11000);
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_LOW + 33'd100, 48'd12000);
        send_item(wcst_pkg::FUNC_QUERY, '1, 48'd12000);
        send_item(wcst_pkg::FUNC_QUERY, '0, '0);
        now_ms = 12000;
        run_phase(250);

        for (int p = 1; p < 6; p++) begin
            settle();
            case (p)
                1: begin
                    cfg_write(wcst_pkg::CFG_MAX_AGE, wcst_pkg::AGE_LOW);
                    cfg_write(wcst_pkg::CFG_BACK_TOL, 20'(wcst_pkg::TOL_HIGH));
                    cfg_write(wcst_pkg::CFG_MAX_AGE, wcst_pkg::AGE_LOW - 20'd1);
                    cfg_write(wcst_pkg::CFG_BACK_TOL, 20'(wcst_pkg::TOL_HIGH) + 20'd1);
                end
                2: begin
                    cfg_write(wcst_pkg::CFG_MAX_AGE, wcst_pkg::AGE_HIGH);
                    cfg_write(wcst_pkg::CFG_MAX_AGE, wcst_pkg::AGE_HIGH + 20'd1);
                    cfg_write(wcst_pkg::CFG_MAX_AGE, 20'hFFFFF);
                    cfg_write(wcst_pkg::CFG_BACK_TOL, 20'hFFE00);
                    cfg_write(wcst_pkg::CFG_BACK_TOL, 20'h001FF);
                end
                default: begin
                    if ($urandom_range(1, 0))
                        cfg_write(wcst_pkg::CFG_MAX_AGE,
                                  20'($urandom_range(32'(wcst_pkg::AGE_HIGH),
                                                     32'(wcst_pkg::AGE_LOW))));
                    else
                        cfg_write(wcst_pkg::CFG_MAX_AGE, 20'($urandom));
                    if ($urandom_range(1, 0))
                        cfg_write(wcst_pkg::CFG_BACK_TOL,
                                  20'($urandom_range(32'(wcst_pkg::TOL_HIGH), 0)));
                    else
                        cfg_write(wcst_pkg::CFG_BACK_TOL, 20'($urandom));
                end
            endcase
            send_idle = (p < 2) ? 30 : (p < 4) ? 46 : 0;
            recv_idle = (p < 2) ? 46 : (p < 4) ? 30 : 0;
            run_phase(250);
        end

        // anchor on the 2100 bound itself, then step off it
        now_ms += 64'd1000;
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_HIGH, 48'(now_ms));
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'(now_ms));
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'(now_ms + 64'd999));
        send_item(wcst_pkg::FUNC_QUERY, '0, 48'(now_ms + 64'd1000));
        send_item(wcst_pkg::FUNC_SYNC, wcst_pkg::TIME_HIGH, 48'(now_ms + 64'd1000));

        settle();
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
